// ===== hw/rtl/rlm_pkg.sv =====
// rlm_pkg: shared types and constants of the rms level meter
// no dependencies

package rlm_pkg;

    localparam int MAX_CHUNK_SAMPLES_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF       = 4;

    localparam int SQRT_ROOT_W = 31;
    localparam int SQRT_RAD_W  = 2 * SQRT_ROOT_W;
    localparam int SQRT_REM_W  = SQRT_ROOT_W + 2;
    localparam int SQUARE_W    = 31;

    localparam logic [1:0] CFG_ALPHA    = 2'd0;
    localparam logic [1:0] CFG_GAIN     = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    localparam logic [15:0] ALPHA_RST    = 16'd22938;
    localparam logic [15:0] GAIN_RST     = 16'd6144;
    localparam logic [15:0] INTERVAL_RST = 16'd33;
    localparam logic [15:0] LEVEL_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] gain;
        logic [15:0] interval;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT1,
        ST_SQRT2,
        ST_GAIN,
        ST_DIFF,
        ST_EMA,
        ST_OUT
    } back_state_t;

endpackage

// ===== hw/rtl/rms_level_meter_ema_top.sv =====
// rms_level_meter_ema_top: top level of the rms level meter with smoothing
// depends on rlm_pkg, rlm_front, rlm_queue, rlm_back

// Samples are taken one per cycle while the job queue has room; a plain sample
// yields no result. A chunk end runs through the back end's divide, two square
// root, gain, difference, smoothing and output states, paced by the
// one-bit-per-cycle divider and the shared one-bit-per-cycle square root; a
// clear goes from idle straight to output there. The job queue holds
// QUEUE_DEPTH chunk ends or clears, so samples keep flowing while the back end works.

module rms_level_meter_ema_top import rlm_pkg::*; #(
    parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_SAMPLES_DEF,
    parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic signed [15:0] s_sample,
    input  logic               s_chunk_end,
    input  logic [31:0]        s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_level,
    output logic               m_notify,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
    localparam int SUM_W = CNT_W + 30;
    localparam int JOB_W = 1 + 32 + CNT_W + SUM_W;

    cfg_t cfg_reg;
    logic q_full, q_empty, q_push, q_pop;
    logic [JOB_W-1:0] q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha    <= ALPHA_RST;
            cfg_reg.gain     <= GAIN_RST;
            cfg_reg.interval <= INTERVAL_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ALPHA:    cfg_reg.alpha    <= cfg_data;
                CFG_GAIN:     cfg_reg.gain     <= cfg_data;
                CFG_INTERVAL: cfg_reg.interval <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    rlm_front #(
        .MAX_CHUNK_SAMPLES(MAX_CHUNK_SAMPLES),
        .CNT_W(CNT_W),
        .SUM_W(SUM_W),
        .JOB_W(JOB_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_sample   (s_sample),
        .s_chunk_end(s_chunk_end),
        .s_now_ms   (s_now_ms),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    rlm_queue #(
        .DATA_W(JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wr_data(q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .empty  (q_empty),
        .rd_data(q_rdata)
    );

    rlm_back #(
        .CNT_W(CNT_W),
        .SUM_W(SUM_W),
        .JOB_W(JOB_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_level (m_level),
        .m_notify(m_notify)
    );

endmodule

// ===== hw/rtl/rlm_front.sv =====
// rlm_front: takes requests, sums squares per chunk, queues chunk and clear jobs
// depends on rlm_pkg

module rlm_front import rlm_pkg::*; #(
    parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_SAMPLES_DEF,
    parameter int CNT_W  = $clog2(MAX_CHUNK_SAMPLES + 1),
    parameter int SUM_W  = CNT_W + 30,
    parameter int JOB_W  = 1 + 32 + CNT_W + SUM_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic signed [15:0] s_sample,
    input  logic               s_chunk_end,
    input  logic [31:0]        s_now_ms,
    input  logic               q_full,
    output logic               q_push,
    output logic [JOB_W-1:0]   q_data
);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [31:0] square;
    logic accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign square  = s_sample * s_sample;

    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (cnt_reg < CNT_W'(MAX_CHUNK_SAMPLES)) begin
            sum_next = sum_reg + SUM_W'(square[SQUARE_W-1:0]);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign q_push = accept && (s_action || s_chunk_end);
    assign q_data = {s_action, s_now_ms, cnt_next, sum_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (accept) begin
            if (s_action || s_chunk_end) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

// ===== hw/rtl/rlm_queue.sv =====
// rlm_queue: small job queue between front and back
// depends on rlm_pkg

module rlm_queue import rlm_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output logic [DATA_W-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = cnt_reg == CNT_W'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/rlm_back.sv =====
// rlm_back: per-chunk divide, two square roots, gain, smoothing and notify
// depends on rlm_pkg

module rlm_back import rlm_pkg::*; #(
    parameter int CNT_W = 11,
    parameter int SUM_W = CNT_W + 30,
    parameter int JOB_W = 1 + 32 + CNT_W + SUM_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             q_empty,
    input  logic [JOB_W-1:0] q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [15:0]      m_level,
    output logic             m_notify
);

    localparam int ITER_W = $clog2(SUM_W);

    back_state_t state_reg, state_next;

    logic             clr_reg;
    logic [31:0]      now_reg;
    logic [CNT_W-1:0] den_reg;
    logic [SUM_W-1:0] num_reg;
    logic [CNT_W-1:0] drem_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [SQRT_RAD_W-1:0]  rad_reg;
    logic [SQRT_REM_W-1:0]  srem_reg;
    logic [SQRT_ROOT_W-1:0] root_reg;
    logic [32:0] prod_reg;
    logic        up_reg;
    logic [15:0] diff_reg;
    logic [31:0] mul_reg;
    logic [15:0] level_reg;
    logic [31:0] last_ms_reg;
    logic        m_valid_reg;
    logic [15:0] m_level_reg;
    logic        m_notify_reg;

    logic             q_clear;
    logic [31:0]      q_now;
    logic [CNT_W-1:0] q_cnt;
    logic [SUM_W-1:0] q_sum;

    logic [CNT_W:0] div_sh, div_sub;
    logic           div_ge;
    logic [SQRT_REM_W+1:0] sq_sh, sq_trial, sq_sub;
    logic                  sq_ge;
    logic [SQRT_ROOT_W-1:0] root_new;
    logic [20:0] norm_wide;
    logic [15:0] norm;
    logic [15:0] level_new;
    logic        notify_new;
    logic        out_fire;
    logic        div_last, sqrt_last;

    assign {q_clear, q_now, q_cnt, q_sum} = q_data;

    assign div_sh  = {drem_reg, num_reg[SUM_W-1]};
    assign div_ge  = div_sh >= {1'b0, den_reg};
    assign div_sub = div_sh - {1'b0, den_reg};

    assign sq_sh    = {srem_reg, rad_reg[SQRT_RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_sub   = sq_sh - sq_trial;
    assign root_new = {root_reg[SQRT_ROOT_W-2:0], sq_ge};

    assign norm_wide = prod_reg[32:12];
    assign norm      = (norm_wide > 21'(LEVEL_MAX)) ? LEVEL_MAX : norm_wide[15:0];

    assign div_last  = iter_reg == ITER_W'(SUM_W - 1);
    assign sqrt_last = iter_reg == ITER_W'(SQRT_ROOT_W - 1);

    always_comb begin
        if (clr_reg) begin
            level_new  = '0;
            notify_new = 1'b1;
        end else begin
            level_new  = up_reg ? level_reg + mul_reg[31:16] : level_reg - mul_reg[31:16];
            notify_new = (now_reg - last_ms_reg) >= {16'd0, cfg.interval};
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = q_clear ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_SQRT1;
                end
            end
            ST_SQRT1: begin
                if (sqrt_last) begin
                    state_next = ST_SQRT2;
                end
            end
            ST_SQRT2: begin
                if (sqrt_last) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_EMA;
            ST_EMA:  state_next = ST_OUT;
            ST_OUT: begin
                if (out_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_pop    = 1'b0;
        out_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: q_pop    = !q_empty;
            ST_OUT:  out_fire = !m_valid_reg || m_ready;
            default: begin
                q_pop    = 1'b0;
                out_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            level_reg    <= '0;
            last_ms_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (out_fire) begin
                m_valid_reg <= 1'b1;
                level_reg   <= level_new;
                if (clr_reg) begin
                    last_ms_reg <= '0;
                end else if (notify_new) begin
                    last_ms_reg <= now_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                clr_reg  <= q_clear;
                now_reg  <= q_now;
                den_reg  <= q_cnt;
                num_reg  <= q_sum;
                drem_reg <= '0;
                iter_reg <= '0;
            end
            ST_DIV: begin
                drem_reg <= div_ge ? div_sub[CNT_W-1:0] : div_sh[CNT_W-1:0];
                num_reg  <= {num_reg[SUM_W-2:0], div_ge};
                if (div_last) begin
                    iter_reg <= '0;
                    rad_reg  <= {1'b0, num_reg[29:0], div_ge, 30'd0};
                    srem_reg <= '0;
                    root_reg <= '0;
                end else begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
            ST_SQRT1, ST_SQRT2: begin
                if (sqrt_last && state_reg == ST_SQRT1) begin
                    iter_reg <= '0;
                    rad_reg  <= {29'd0, root_new, 2'b00};
                    srem_reg <= '0;
                    root_reg <= '0;
                end else begin
                    srem_reg <= sq_ge ? sq_sub[SQRT_REM_W-1:0] : sq_sh[SQRT_REM_W-1:0];
                    root_reg <= root_new;
                    rad_reg  <= {rad_reg[SQRT_RAD_W-3:0], 2'b00};
                    iter_reg <= sqrt_last ? '0 : iter_reg + 1'b1;
                end
            end
            ST_GAIN: prod_reg <= root_reg[16:0] * cfg.gain;
            ST_DIFF: begin
                up_reg   <= norm >= level_reg;
                diff_reg <= (norm >= level_reg) ? norm - level_reg : level_reg - norm;
            end
            ST_EMA: mul_reg <= diff_reg * cfg.alpha;
            ST_OUT: begin
                if (out_fire) begin
                    m_level_reg  <= level_new;
                    m_notify_reg <= notify_new;
                end
            end
            default: begin
                iter_reg <= '0;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_level  = m_level_reg;
    assign m_notify = m_notify_reg;

endmodule

// ===== hw/rtl/rlm_checker.sv =====
// rlm_checker: port-level assertions for the rms level meter
// depends on rms_level_meter_ema_top, bound to it below

module rlm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_level,
    input logic        m_notify,
    input logic        cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_notify))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // reset empties the job queue
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port stalled");

endmodule

bind rms_level_meter_ema_top rlm_checker u_rlm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_level  (m_level),
    .m_notify (m_notify),
    .cfg_ready(cfg_ready)
);
